// ----- hw/rtl/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Shared widths, command and status codes and the cell control bundle
// for the integer set store.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 2;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 3;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic              ins;
    logic              del;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/iss_req_if.sv -----
// ----------------------------------------------------------------------------
// iss_req_if
// Command channel of the integer set store: valid/ready plus one command.
// ----------------------------------------------------------------------------
interface iss_req_if;
  logic                                valid;
  logic                                ready;
  logic [iss_pkg::CMD_W-1:0]           cmd;
  logic signed [iss_pkg::DATA_W-1:0]   value;
  logic [iss_pkg::POS_W-1:0]           position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

// ----- hw/rtl/iss_rsp_if.sv -----
// ----------------------------------------------------------------------------
// iss_rsp_if
// Result channel of the integer set store: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface iss_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [iss_pkg::STAT_W-1:0]          status;
  logic                                found;
  logic signed [iss_pkg::DATA_W-1:0]   read_value;
  logic [iss_pkg::COUNT_W-1:0]         count;

  modport source (output valid, output status, output found, output read_value,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input count, output ready);
endinterface

// ----- hw/rtl/iss_cell.sv -----
// ----------------------------------------------------------------------------
// iss_cell
// One slot of the set. Holds one element, compares it against the key and
// passes a registered hit flag and read data on to the next cell.
// ----------------------------------------------------------------------------
module iss_cell (
  input  logic                        clk,
  input  logic [iss_pkg::IDX_W-1:0]   idx,
  input  iss_pkg::cell_ctrl_t         ctrl,
  input  logic                        hit_in,
  input  logic [iss_pkg::DATA_W-1:0]  data_in,
  input  logic [iss_pkg::DATA_W-1:0]  right,
  output logic [iss_pkg::DATA_W-1:0]  elem,
  output logic                        hit,
  output logic [iss_pkg::DATA_W-1:0]  data
);

  logic [iss_pkg::CNT_W-1:0] idx_ext;
  logic                      occupied;

  assign idx_ext  = iss_pkg::CNT_W'(idx);
  assign occupied = idx_ext < ctrl.count;

  always_ff @(posedge clk) begin
    if (ctrl.ins && (idx_ext == ctrl.count)) begin
      elem <= ctrl.key;
    end else if (ctrl.del && hit) begin
      elem <= right;
    end
    hit  <= hit_in | (occupied && (elem == ctrl.key));
    data <= (idx_ext == ctrl.pos) ? elem : data_in;
  end

endmodule

// ----- hw/rtl/integer_set_store.sv -----
// ----------------------------------------------------------------------------
// integer_set_store
// Bounded set of distinct signed 32-bit integers kept in insertion order.
// ----------------------------------------------------------------------------
// The set lives in a row of CAPACITY cells, one element per cell. A command
// is latched, then a hit flag and a read tap ripple down the row one cell
// per cycle. Each item passes through S_IDLE, where it is accepted, S_SCAN,
// where the row is swept, and S_DONE, which commits the insert or the
// shift-down of a remove and loads the result register. A new command is
// taken only once the previous one has committed; a result waits in the
// output register until taken and stalls the commit of the next one.
// ----------------------------------------------------------------------------
module integer_set_store (
  input  logic          clk,
  input  logic          rst,
  iss_req_if.sink       req,
  iss_rsp_if.source     rsp
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam int N = iss_pkg::CAPACITY;

  state_t                        state;
  logic [iss_pkg::IDX_W-1:0]     scan;
  iss_pkg::cmd_t                 cmd;
  logic [iss_pkg::DATA_W-1:0]    key;
  logic [iss_pkg::POS_W-1:0]     pos;
  logic [iss_pkg::CNT_W-1:0]     count;
  logic [iss_pkg::CNT_W-1:0]     count_next;

  logic                          out_valid;
  logic [iss_pkg::STAT_W-1:0]    out_status;
  logic                          out_found;
  logic [iss_pkg::DATA_W-1:0]    out_read;
  logic [iss_pkg::COUNT_W-1:0]   out_count;

  logic [iss_pkg::DATA_W-1:0]    elem [N];
  logic                          hit  [N];
  logic [iss_pkg::DATA_W-1:0]    data [N];

  iss_pkg::cell_ctrl_t           ctrl;
  iss_pkg::status_t              status;
  logic                          commit;
  logic                          found;
  logic                          is_full;
  logic                          read_ok;
  logic [iss_pkg::CNT_W-1:0]     pos_ext;

  assign pos_ext = iss_pkg::CNT_W'(pos);
  assign found   = hit[N-1];
  assign is_full = count >= iss_pkg::CNT_W'(N);
  assign read_ok = pos_ext < count;
  assign commit  = (state == S_DONE) && (!out_valid || rsp.ready);

  assign ctrl.key   = key;
  assign ctrl.pos   = pos_ext;
  assign ctrl.count = count;
  assign ctrl.ins   = commit && (cmd == iss_pkg::CMD_INSERT) && !found && !is_full;
  assign ctrl.del   = commit && (cmd == iss_pkg::CMD_REMOVE) && found;

  always_comb begin
    status     = iss_pkg::ST_OK;
    count_next = count;
    case (cmd)
      iss_pkg::CMD_INSERT: begin
        if (found) begin
          status = iss_pkg::ST_PRESENT;
        end else if (is_full) begin
          status = iss_pkg::ST_FULL;
        end else begin
          count_next = count + iss_pkg::CNT_W'(1);
        end
      end
      iss_pkg::CMD_REMOVE: begin
        if (!found) begin
          status = iss_pkg::ST_ABSENT;
        end else begin
          count_next = count - iss_pkg::CNT_W'(1);
        end
      end
      iss_pkg::CMD_QUERY: begin
        status = iss_pkg::ST_OK;
      end
      iss_pkg::CMD_READ: begin
        if (!read_ok) begin
          status = iss_pkg::ST_RANGE;
        end
      end
      default: begin
        status = iss_pkg::ST_OK;
      end
    endcase
  end

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                       hit_in;
    logic [iss_pkg::DATA_W-1:0] data_in;
    logic [iss_pkg::DATA_W-1:0] right;

    if (i == 0) begin : g_head
      assign hit_in  = 1'b0;
      assign data_in = '0;
    end else begin : g_body
      assign hit_in  = hit[i-1];
      assign data_in = data[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right = elem[i];
    end else begin : g_mid
      assign right = elem[i+1];
    end

    iss_cell u_cell (
      .clk     (clk),
      .idx     (iss_pkg::IDX_W'(i)),
      .ctrl    (ctrl),
      .hit_in  (hit_in),
      .data_in (data_in),
      .right   (right),
      .elem    (elem[i]),
      .hit     (hit[i]),
      .data    (data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      scan      <= '0;
    end else begin
      if (rsp.valid && rsp.ready && !commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_SCAN;
            scan  <= '0;
          end
        end
        S_SCAN: begin
          scan <= scan + iss_pkg::IDX_W'(1);
          if (scan == iss_pkg::IDX_W'(N - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            out_valid <= 1'b1;
            count     <= count_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd <= iss_pkg::cmd_t'(req.cmd);
      key <= req.value;
      pos <= req.position;
    end
    if (commit) begin
      out_status <= status;
      out_found  <= (cmd == iss_pkg::CMD_QUERY) && found;
      out_read   <= ((cmd == iss_pkg::CMD_READ) && read_ok) ? data[N-1] : '0;
      out_count  <= iss_pkg::COUNT_W'(count_next);
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found      = out_found;
  assign rsp.read_value = out_read;
  assign rsp.count      = out_count;

endmodule
